// ----- hw/rtl/hee_pkg.sv -----
// Package for the 2x2 Hessian eigen block: stage payload types and step counts.
// Used by hee_sqrt_cell, hee_div_cell and hessian_eigen_2x2_top; no dependencies.
package hee_pkg;

    localparam int SQ_STEPS = 34;   // root bits of the square-root chains
    localparam int DV_STEPS = 31;   // quotient bits of the divider chains
    localparam logic [15:0] ONE_Q14 = 16'sd16384;

    // Item context that rides alongside the arithmetic chains.
    typedef struct packed {
        logic signed [31:0] rr;
        logic signed [31:0] cc;
        logic [31:0]        ab;     // |rc|
        logic [31:0]        ad;     // |cc - rr|
        logic               neg;    // rotation tangent is negative
        logic               rcneg;
        logic               zero;   // rc is zero: identity rotation
        logic [30:0]        tm;     // |t| in Q1.30
        logic [32:0]        pr;     // rounded |t * rc|
    } t_side;

    // Square-root cell word: radicand bits still to feed, remainder, partial root.
    typedef struct packed {
        logic [67:0] rad;
        logic [36:0] rem;
        logic [33:0] root;
    } t_sq;

    // Divider cell word: dividend bits still to feed, remainder, divisor, quotient.
    typedef struct packed {
        logic [30:0] numlo;
        logic [34:0] rem;
        logic [33:0] den;
        logic [30:0] quo;
    } t_dv;

endpackage

// ----- hw/rtl/hee_sqrt_cell.sv -----
// One stage of the digit-by-digit square-root chain: resolves one root bit.
// Depends on hee_pkg.
module hee_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  hee_pkg::t_side i_side,
    input  hee_pkg::t_sq   i_sq,
    output logic           o_vld,
    output hee_pkg::t_side o_side,
    output hee_pkg::t_sq   o_sq
);
    import hee_pkg::*;

    logic [36:0] rem2;
    logic [36:0] trial;
    logic        ge;
    t_sq         n_sq;
    logic        r_vld;
    t_side       r_side;
    t_sq         r_sq;

    always_comb begin
        rem2  = {i_sq.rem[34:0], i_sq.rad[67:66]};
        trial = {1'b0, i_sq.root, 2'b01};
        ge    = (rem2 >= trial);
        n_sq.rad  = {i_sq.rad[65:0], 2'b00};
        n_sq.rem  = ge ? (rem2 - trial) : rem2;
        n_sq.root = {i_sq.root[32:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side <= i_side;
        r_sq   <= n_sq;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_sq   = r_sq;
endmodule

// ----- hw/rtl/hee_div_cell.sv -----
// One stage of the restoring divider chain: resolves one quotient bit.
// Depends on hee_pkg.
module hee_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  hee_pkg::t_side i_side,
    input  hee_pkg::t_dv   i_dv,
    output logic           o_vld,
    output hee_pkg::t_side o_side,
    output hee_pkg::t_dv   o_dv
);
    import hee_pkg::*;

    logic [34:0] rem2;
    logic [34:0] dext;
    logic        ge;
    t_dv         n_dv;
    logic        r_vld;
    t_side       r_side;
    t_dv         r_dv;

    always_comb begin
        rem2 = {i_dv.rem[33:0], i_dv.numlo[30]};
        dext = {1'b0, i_dv.den};
        ge   = (rem2 >= dext);
        n_dv.numlo = {i_dv.numlo[29:0], 1'b0};
        n_dv.rem   = ge ? (rem2 - dext) : rem2;
        n_dv.den   = i_dv.den;
        n_dv.quo   = {i_dv.quo[29:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side <= i_side;
        r_dv   <= n_dv;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_dv   = r_dv;
endmodule

// ----- hw/rtl/hessian_eigen_2x2_top.sv -----
// Eigen-decomposition of a symmetric 2x2 Hessian word by one Jacobi rotation.
// Pipeline: 140 register stages end to end, from the capture register to the ordering
// stage; o_valid rises together with the result word.
// Throughput: one word per cycle; busy is never raised, set by the fully
// pipelined chains (two 34-cell square-root chains, two 31-cell divider chains).
// Reset: synchronous active-low i_rst_n clears every valid bit; no strobe follows.
// Depends on hee_pkg, hee_sqrt_cell, hee_div_cell.
module hessian_eigen_2x2_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_hess_rr,
    input  logic signed [31:0] i_hess_rc,
    input  logic signed [31:0] i_hess_cc,
    output logic               o_valid,
    output logic signed [32:0] o_eig_major,
    output logic signed [32:0] o_eig_minor,
    output logic signed [15:0] o_vec_major_r,
    output logic signed [15:0] o_vec_major_c,
    output logic signed [15:0] o_vec_minor_r,
    output logic signed [15:0] o_vec_minor_c
);
    import hee_pkg::*;

    // ---------------- capture ----------------
    logic               r1_vld;
    logic signed [31:0] r1_rr, r1_rc, r1_cc;

    // ---------------- abs values and squares ----------------
    logic signed [32:0] n_d;
    logic [31:0]        n_ad, n_ab;
    t_side              n2_side, r2_side;
    logic               r2_vld;
    logic [63:0]        r2_d2, r2_b2;

    // ---------------- radicand d^2 + 4 rc^2 ----------------
    logic               r3_vld;
    t_side              r3_side;
    t_sq                r3_sq;

    logic               sa_vld  [SQ_STEPS+1];
    t_side              sa_side [SQ_STEPS+1];
    t_sq                sa_sq   [SQ_STEPS+1];

    logic               r4_vld;
    t_side              r4_side;
    t_dv                r4_dv;

    logic               da_vld  [DV_STEPS+1];
    t_side              da_side [DV_STEPS+1];
    t_dv                da_dv   [DV_STEPS+1];

    logic               r5_vld;
    t_side              n5_side, r5_side;
    logic [61:0]        r5_tsq;
    logic [62:0]        r5_pm;
    logic [63:0]        n_pm_rnd;

    logic               r6_vld;
    t_side              n6_side, r6_side;
    t_sq                r6_sq;

    logic               sb_vld  [SQ_STEPS+1];
    t_side              sb_side [SQ_STEPS+1];
    t_sq                sb_sq   [SQ_STEPS+1];

    logic               r7_vld;
    t_side              r7_side;
    t_dv                r7_dv;

    logic               db_vld  [DV_STEPS+1];
    t_side              db_side [DV_STEPS+1];
    t_dv                db_dv   [DV_STEPS+1];

    logic               r8_vld;
    t_side              r8_side;
    logic [30:0]        r8_c30;
    logic [61:0]        r8_sp;

    // ---------------- rounding and eigenvalues ----------------
    logic [31:0]        n_cs;
    logic [32:0]        n_ss;
    logic signed [15:0] n_c14, n_s14;
    logic signed [33:0] n_p, n_e1, n_e2;
    logic               r9_vld;
    logic signed [15:0] r9_c14, r9_s14;
    logic signed [32:0] r9_e1, r9_e2;

    // ---------------- ordering ----------------
    logic signed [33:0] n_a1, n_a2;
    logic               n_e1_first;
    logic               r_vld;
    logic signed [32:0] r_maj, r_mnr;
    logic signed [15:0] r_mjr, r_mjc, r_mnr_r, r_mnr_c;

    assign busy = 1'b0;

    // Capture the word whenever start is high; busy never blocks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_rr <= i_hess_rr;
        r1_rc <= i_hess_rc;
        r1_cc <= i_hess_cc;
    end

    // Take magnitudes and the tangent sign; square both terms.
    always_comb begin
        n_d  = 33'(r1_cc) - 33'(r1_rr);
        n_ad = n_d[32] ? 32'(-n_d) : n_d[31:0];
        n_ab = r1_rc[31] ? 32'(-33'(r1_rc)) : 32'(r1_rc);
        n2_side       = '0;
        n2_side.rr    = r1_rr;
        n2_side.cc    = r1_cc;
        n2_side.ab    = n_ab;
        n2_side.ad    = n_ad;
        n2_side.rcneg = r1_rc[31];
        n2_side.zero  = (r1_rc == 32'sd0);
        n2_side.neg   = (n_d[32] && !r1_rc[31] && r1_rc != 32'sd0) ||
                        (!n_d[32] && n_d != 33'sd0 && r1_rc[31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        r2_side <= n2_side;
        r2_d2   <= n_ad * n_ad;
        r2_b2   <= n_ab * n_ab;
        r3_side <= r2_side;
        r3_sq.rad  <= {4'b0000, r2_d2} + {2'b00, r2_b2, 2'b00};
        r3_sq.rem  <= '0;
        r3_sq.root <= '0;
    end

    // First root: r = floor(sqrt(d^2 + 4 rc^2)).
    assign sa_vld[0]  = r3_vld;
    assign sa_side[0] = r3_side;
    assign sa_sq[0]   = r3_sq;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqa
        hee_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sa_vld[g]),
            .i_side (sa_side[g]),
            .i_sq   (sa_sq[g]),
            .o_vld  (sa_vld[g+1]),
            .o_side (sa_side[g+1]),
            .o_sq   (sa_sq[g+1])
        );
    end

    // Load divider: |t| = 2|rc| * 2^30 / (|d| + r); the top dividend bits are |rc|.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= sa_vld[SQ_STEPS];
        end
        r4_side     <= sa_side[SQ_STEPS];
        r4_dv.numlo <= '0;
        r4_dv.rem   <= {3'b000, sa_side[SQ_STEPS].ab};
        r4_dv.den   <= {2'b00, sa_side[SQ_STEPS].ad} + sa_sq[SQ_STEPS].root;
        r4_dv.quo   <= '0;
    end

    assign da_vld[0]  = r4_vld;
    assign da_side[0] = r4_side;
    assign da_dv[0]   = r4_dv;

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_dva
        hee_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (da_vld[g]),
            .i_side (da_side[g]),
            .i_dv   (da_dv[g]),
            .o_vld  (da_vld[g+1]),
            .o_side (da_side[g+1]),
            .o_dv   (da_dv[g+1])
        );
    end

    // Square t for the cosine, and form t * |rc| for the eigenvalue shift.
    always_comb begin
        n_pm_rnd   = {1'b0, r5_pm} + 64'(1 << 29);
        n5_side    = da_side[DV_STEPS];
        n5_side.tm = da_dv[DV_STEPS].quo;
        n6_side    = r5_side;
        n6_side.pr = n_pm_rnd[62:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r5_vld <= da_vld[DV_STEPS];
            r6_vld <= r5_vld;
        end
        r5_side    <= n5_side;
        r5_tsq     <= da_dv[DV_STEPS].quo * da_dv[DV_STEPS].quo;
        r5_pm      <= da_dv[DV_STEPS].quo * da_side[DV_STEPS].ab;
        r6_side    <= n6_side;
        r6_sq.rad  <= 68'(64'd1 << 60) + {6'd0, r5_tsq};
        r6_sq.rem  <= '0;
        r6_sq.root <= '0;
    end

    // Second root: q = floor(sqrt(2^60 + t^2)).
    assign sb_vld[0]  = r6_vld;
    assign sb_side[0] = r6_side;
    assign sb_sq[0]   = r6_sq;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqb
        hee_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sb_vld[g]),
            .i_side (sb_side[g]),
            .i_sq   (sb_sq[g]),
            .o_vld  (sb_vld[g+1]),
            .o_side (sb_side[g+1]),
            .o_sq   (sb_sq[g+1])
        );
    end

    // Load divider: c = 2^60 / q; the top dividend bits are 2^29.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= sb_vld[SQ_STEPS];
        end
        r7_side     <= sb_side[SQ_STEPS];
        r7_dv.numlo <= '0;
        r7_dv.rem   <= 35'(1) << 29;
        r7_dv.den   <= sb_sq[SQ_STEPS].root;
        r7_dv.quo   <= '0;
    end

    assign db_vld[0]  = r7_vld;
    assign db_side[0] = r7_side;
    assign db_dv[0]   = r7_dv;

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_dvb
        hee_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (db_vld[g]),
            .i_side (db_side[g]),
            .i_dv   (db_dv[g]),
            .o_vld  (db_vld[g+1]),
            .o_side (db_side[g+1]),
            .o_dv   (db_dv[g+1])
        );
    end

    // Sine magnitude: s = t * c / 2^30.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= db_vld[DV_STEPS];
        end
        r8_side <= db_side[DV_STEPS];
        r8_c30  <= db_dv[DV_STEPS].quo;
        r8_sp   <= db_side[DV_STEPS].tm * db_dv[DV_STEPS].quo;
    end

    // Round to Q1.14, apply signs, drop the rotation when rc is zero.
    always_comb begin
        n_cs  = {1'b0, r8_c30} + 32'(1 << 15);
        n_ss  = {1'b0, r8_sp[61:30]} + 33'(1 << 15);
        n_c14 = r8_side.zero ? ONE_Q14 : n_cs[31:16];
        if (r8_side.zero) begin
            n_s14 = 16'sd0;
        end else if (r8_side.neg) begin
            n_s14 = -n_ss[31:16];
        end else begin
            n_s14 = n_ss[31:16];
        end
        if (r8_side.zero) begin
            n_p = 34'sd0;
        end else if (r8_side.neg ^ r8_side.rcneg) begin
            n_p = -$signed({1'b0, r8_side.pr});
        end else begin
            n_p = $signed({1'b0, r8_side.pr});
        end
        n_e1 = 34'(r8_side.rr) - n_p;
        n_e2 = 34'(r8_side.cc) + n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
        r9_c14 <= n_c14;
        r9_s14 <= n_s14;
        r9_e1  <= n_e1[32:0];
        r9_e2  <= n_e2[32:0];
    end

    // Order by magnitude; on a tie the more negative value leads.
    always_comb begin
        n_a1 = r9_e1[32] ? -34'(r9_e1) : 34'(r9_e1);
        n_a2 = r9_e2[32] ? -34'(r9_e2) : 34'(r9_e2);
        if (n_a1 != n_a2) begin
            n_e1_first = (n_a1 > n_a2);
        end else begin
            n_e1_first = (r9_e1 < r9_e2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r9_vld;
        end
        if (n_e1_first) begin
            r_maj   <= r9_e1;
            r_mnr   <= r9_e2;
            r_mjr   <= r9_c14;
            r_mjc   <= -r9_s14;
            r_mnr_r <= r9_s14;
            r_mnr_c <= r9_c14;
        end else begin
            r_maj   <= r9_e2;
            r_mnr   <= r9_e1;
            r_mjr   <= r9_s14;
            r_mjc   <= r9_c14;
            r_mnr_r <= r9_c14;
            r_mnr_c <= -r9_s14;
        end
    end

    assign o_valid       = r_vld;
    assign o_eig_major   = r_maj;
    assign o_eig_minor   = r_mnr;
    assign o_vec_major_r = r_mjr;
    assign o_vec_major_c = r_mjc;
    assign o_vec_minor_r = r_mnr_r;
    assign o_vec_minor_c = r_mnr_c;

    // Major vector components never leave the unit range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vec_major_r <= 16'sd16384 && o_vec_major_r >= -16'sd16384 &&
                     o_vec_major_c <= 16'sd16384 && o_vec_major_c >= -16'sd16384))
        else $error("major vector out of range");

    // Minor vector is the major one turned by a quarter, one way or the other.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_vec_minor_r == -o_vec_major_c && o_vec_minor_c == o_vec_major_r) ||
                     (o_vec_minor_r == o_vec_major_c && o_vec_minor_c == -o_vec_major_r)))
        else $error("minor vector not orthogonal to major");

    // A word in the rounding stage leaves the ordering stage in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_vld |=> o_valid)
        else $error("strobe lost in output stage");
endmodule
